// ----- sv/mp_pkg.sv -----
// Package for the multiplicative persistence unit.
// Holds the shared widths, constants and the control state type.
// No dependencies.
`timescale 1ns / 1ps

package mp_pkg;

    // Width of the binary value that is worked on in each round.
    localparam int ValueW    = 63;
    // One decimal digit in BCD.
    localparam int DigitW    = 4;
    // Decimal digits needed for any value below 2^63.
    localparam int BcdDigits = 19;
    localparam int BcdW      = BcdDigits * DigitW;
    // Width of the round count.
    localparam int CountW    = 4;

    // Counter width for the bit-serial conversion (one input bit per cycle).
    localparam int ConvCntW  = $clog2(ValueW);

    localparam logic [CountW-1:0] CountMax = 4'd15;
    // Largest persistence reachable for a 63-bit input.
    localparam logic [CountW-1:0] PersMax  = 4'd11;
    // Values below this are a single decimal digit.
    localparam logic [ValueW-1:0] Radix    = ValueW'(10);

    // Control states of the top-level sequencer.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CONV,
        S_MULT,
        S_DONE
    } t_mp_state;

endpackage

// ----- sv/mp_bcd_conv.sv -----
// Bit-serial binary to BCD converter (shift and add 3), one input bit per cycle.
// Depends on mp_pkg for the value and BCD widths.
`timescale 1ns / 1ps

module mp_bcd_conv import mp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ValueW-1:0] i_value,
    output logic              o_done,
    output logic [BcdW-1:0]   o_bcd
);

    logic [ValueW-1:0]   r_shift, n_shift;
    logic [BcdW-1:0]     r_bcd, n_bcd;
    logic [ConvCntW-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [BcdW-1:0]     w_adj;

    // Add 3 to every BCD digit of 5 or more before the next shift.
    always_comb begin
        for (int d = 0; d < BcdDigits; d++) begin
            if (r_bcd[d*DigitW +: DigitW] >= 4'd5) begin
                w_adj[d*DigitW +: DigitW] = r_bcd[d*DigitW +: DigitW] + 4'd3;
            end else begin
                w_adj[d*DigitW +: DigitW] = r_bcd[d*DigitW +: DigitW];
            end
        end
    end

    // Load on start, then move one bit from the binary side into the BCD side.
    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_value;
            n_bcd   = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_bcd   = {w_adj[BcdW-2:0], r_shift[ValueW-1]};
            n_shift = {r_shift[ValueW-2:0], 1'b0};
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == ConvCntW'(ValueW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the data path is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ----- sv/mp_digit_mult.sv -----
// Digit-serial product of BCD digits, one decimal digit per cycle.
// Depends on mp_pkg for the value and BCD widths.
`timescale 1ns / 1ps

module mp_digit_mult import mp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BcdW-1:0]   i_bcd,
    output logic              o_done,
    output logic [ValueW-1:0] o_product
);

    logic [BcdW-1:0]          r_digits, n_digits;
    logic [ValueW-1:0]        r_prod, n_prod;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [ValueW+DigitW-1:0] w_full;

    // Product times the lowest remaining digit: a 63 by 4 bit multiply.
    assign w_full = r_prod * r_digits[DigitW-1:0];

    // Leading zero digits are not digits of the number, so the walk stops
    // as soon as nothing is left above the current position.
    always_comb begin
        n_digits = r_digits;
        n_prod   = r_prod;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_start) begin
            n_digits = i_bcd;
            n_prod   = ValueW'(1);
            n_busy   = 1'b1;
        end else if (r_busy) begin
            if (r_digits == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_prod   = w_full[ValueW-1:0];
                n_digits = {{DigitW{1'b0}}, r_digits[BcdW-1:DigitW]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_prod   <= n_prod;
    end

    assign o_done    = r_done;
    assign o_product = r_prod;

endmodule

// ----- sv/multiplicative_persistence_unit.sv -----
// Multiplicative persistence unit.
// Input channel: i_in_valid / o_in_ready with i_start_value (63 bits).
// Output channel: o_out_valid / i_out_ready with o_persistence (4 bits), one
// result per request, in request order.
// A request is taken only while the sequencer is idle; one item is worked on
// at a time. Each round converts the value to BCD one bit per cycle, then
// multiplies its decimal digits one digit per cycle. An item takes at most
// eleven rounds; a single-digit input takes none.
// The bit-serial BCD conversion sets the pace of every round.
// The result sits in an output register. While it waits, the next request
// is already accepted and worked on; a finished result then waits in the
// done state until the output register is free.
// Reset (synchronous, active low) drops any item in flight and clears the
// output valid; the block is ready from the first cycle after reset is
// released and never accepts a request while reset is held.
// Depends on mp_pkg, mp_bcd_conv and mp_digit_mult.
`timescale 1ns / 1ps

module multiplicative_persistence_unit import mp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ValueW-1:0] i_start_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CountW-1:0] o_persistence
);

    t_mp_state          r_state, n_state;
    logic [ValueW-1:0]  r_value, n_value;
    logic [CountW-1:0]  r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic [CountW-1:0]  r_out_pers, n_out_pers;

    logic               w_accept;
    logic               w_conv_start;
    logic               w_conv_done;
    logic [BcdW-1:0]    w_bcd;
    logic               w_mult_start;
    logic               w_mult_done;
    logic [ValueW-1:0]  w_product;

    assign w_accept = i_in_valid && o_in_ready;

    // Digit extraction and digit product units.
    mp_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_conv_start),
        .i_value (r_value),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    mp_digit_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mult_start),
        .i_bcd     (w_bcd),
        .o_done    (w_mult_done),
        .o_product (w_product)
    );

    // Sequencer: check for a single digit, convert, multiply, repeat; then hand the count to the output.
    always_comb begin
        n_state      = r_state;
        n_value      = r_value;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_pers   = r_out_pers;
        o_in_ready   = 1'b0;
        w_conv_start = 1'b0;
        w_mult_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    n_value = i_start_value;
                    n_count = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_value < Radix) begin
                    n_state = S_DONE;
                end else begin
                    w_conv_start = 1'b1;
                    if (r_count != CountMax) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_conv_done) begin
                    w_mult_start = 1'b1;
                    n_state      = S_MULT;
                end
            end
            S_MULT: begin
                if (w_mult_done) begin
                    n_value = w_product;
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_pers  = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_count    <= n_count;
        r_out_pers <= n_out_pers;
    end

    assign o_out_valid   = r_out_valid;
    assign o_persistence = r_out_pers;

`ifndef SYNTHESIS
    // No input in range has a persistence above eleven.
    a_pers_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_persistence <= PersMax))
        else $error("persistence above the reachable maximum");

    // An accepted request starts a fresh count at the single-digit check.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CHECK) && (r_count == '0))
        else $error("accepted request did not start at the check state");

    // The converter only finishes while the sequencer waits for it.
    a_conv_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_done |-> (r_state == S_CONV))
        else $error("conversion finished outside the conversion state");

    // A finished product always goes back to the single-digit check.
    a_mult_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULT) && w_mult_done |=> (r_state == S_CHECK))
        else $error("product did not return to the check state");
`endif

endmodule

// ----- sim/multiplicative_persistence_unit_tb.sv -----
// Testbench for the multiplicative persistence unit: directed table, then random requests.
// Results are checked against a digit-product predictor, with random gaps and stalls.
// Depends on mp_pkg and multiplicative_persistence_unit.
`timescale 1ns / 1ps

module multiplicative_persistence_unit_tb;
    import mp_pkg::*;

    localparam int RandomRequests = 850;
    localparam int DrainCycles    = 1000;
    localparam int DirRows        = 22;

    // Receiver behavior, picked anew for each stretch of cycles.
    typedef enum int {
        RDY_OPEN,
        RDY_COIN,
        RDY_SPARSE,
        RDY_HOLD
    } t_rdy_mode;

    // One directed request; pers is used only where known is set.
    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              known;
        logic [CountW-1:0] pers;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [ValueW-1:0] i_start_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CountW-1:0] o_persistence;

    // Persistence values still owed by the block, oldest first.
    logic [CountW-1:0] pers_queue [$];
    int                mismatch_count = 0;

    t_dir_row dir_rows [0:DirRows-1] = '{
        '{63'd0,                   1'b1, 4'd0},
        '{63'd9,                   1'b1, 4'd0},
        '{63'd10,                  1'b1, 4'd1},
        '{63'd11,                  1'b1, 4'd1},
        '{63'd25,                  1'b0, 4'd0},
        '{63'd39,                  1'b0, 4'd0},
        '{63'd77,                  1'b0, 4'd0},
        '{63'd679,                 1'b0, 4'd0},
        '{63'd6788,                1'b0, 4'd0},
        '{63'd68889,               1'b0, 4'd0},
        '{63'd2677889,             1'b0, 4'd0},
        '{63'd26888999,            1'b0, 4'd0},
        '{63'd3778888999,          1'b0, 4'd0},
        '{63'd277777788888899,     1'b0, 4'd0},
        '{63'd100000000000000000,  1'b1, 4'd1},
        '{63'd1111111111111111111, 1'b1, 4'd1},
        '{63'd4611686018427387904, 1'b1, 4'd1},
        '{63'd5555555555555555555, 1'b0, 4'd0},
        '{63'd8999999999999999999, 1'b0, 4'd0},
        '{63'd9223372036854775807, 1'b1, 4'd1},
        '{63'd9223372036854775806, 1'b1, 4'd1},
        '{63'd6150012345678998765, 1'b0, 4'd0}
    };

    multiplicative_persistence_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_start_value (i_start_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_persistence (o_persistence)
    );

    // Free-running clock, 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Count digit-product rounds until a single decimal digit remains.
    function automatic logic [CountW-1:0] calc_persistence(input logic [ValueW-1:0] start);
        logic [63:0] v;
        logic [63:0] prod;
        logic [63:0] rest;
        int unsigned rounds;
        v = {1'b0, start};
        rounds = 0;
        while (v >= 64'd10 && rounds < 64) begin
            prod = 64'd1;
            rest = v;
            while (rest != 64'd0) begin
                prod = prod * (rest % 64'd10);
                rest = rest / 64'd10;
            end
            v = prod;
            rounds++;
        end
        if (rounds > CountMax) begin
            return CountMax;
        end
        return rounds[CountW-1:0];
    endfunction

    // Random start value: raw bit patterns, small numbers, and digit strings
    // without zeros, which are the ones that run many rounds.
    function automatic logic [ValueW-1:0] rand_start_value();
        logic [63:0] acc;
        int unsigned len;
        int unsigned d;
        int unsigned i;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        acc = {$urandom, $urandom};
        if (pick <= 1) begin
            return acc[ValueW-1:0];
        end
        if (pick == 2) begin
            return ValueW'($urandom_range(0, 999));
        end
        if (pick == 9) begin
            return acc[ValueW-1:0] >> $urandom_range(0, ValueW-1);
        end
        len = $urandom_range(1, BcdDigits);
        acc = 64'd0;
        for (i = 0; i < len; i++) begin
            if (pick >= 6) begin
                case ($urandom_range(0, 4))
                    0: d = 2;
                    1: d = 3;
                    2: d = 7;
                    3: d = 8;
                    default: d = 9;
                endcase
            end else begin
                d = $urandom_range(1, 9);
            end
            // A 19-digit value must stay below 2^63.
            if (i == 0 && len == BcdDigits && d > 8) begin
                d = 8;
            end
            acc = acc * 64'd10 + 64'(d);
        end
        return acc[ValueW-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Present one request at the falling edge and hold it until accepted.
    task automatic send_request(input logic [ValueW-1:0] value, input logic [CountW-1:0] pers);
        i_in_valid    <= 1'b1;
        i_start_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pers_queue.push_back(pers);
        @(negedge i_clk);
    endtask

    // Sender: directed table, then random requests in bursts.
    initial begin
        logic [ValueW-1:0] value;
        int                burst;
        int                gap;
        int                sent;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_start_value = '0;
        i_out_ready   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DirRows; r++) begin
            if (dir_rows[r].known) begin
                send_request(dir_rows[r].value, dir_rows[r].pers);
            end else begin
                send_request(dir_rows[r].value, calc_persistence(dir_rows[r].value));
            end
            if ($urandom_range(0, 2) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end

        sent = 0;
        while (sent < RandomRequests) begin
            // Mostly short bursts with gaps; now and then a long run with none.
            if ($urandom_range(0, 7) == 0) begin
                burst = 30;
                gap   = 0;
            end else begin
                burst = $urandom_range(1, 6);
                gap   = $urandom_range(0, 30);
            end
            for (int b = 0; b < burst && sent < RandomRequests; b++) begin
                value = rand_start_value();
                send_request(value, calc_persistence(value));
                sent++;
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        // Wait for every owed result, then watch for strays.
        while (pers_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: ready follows a randomly picked mode.
    initial begin
        t_rdy_mode mode;
        int        mode_left;
        logic      rdy;
        mode      = RDY_OPEN;
        mode_left = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (mode_left == 0) begin
                mode      = t_rdy_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
                RDY_OPEN:   rdy = 1'b1;
                RDY_COIN:   rdy = 1'($urandom_range(0, 1));
                RDY_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:    rdy = (mode_left == 0);
            endcase
            i_out_ready <= rdy;
            @(negedge i_clk);
        end
    end

    // Compare each accepted result with the oldest owed value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pers_queue.size() == 0) begin
                report_mismatch("result with no request waiting", int'(o_persistence), -1);
            end else begin
                if (o_persistence !== pers_queue[0]) begin
                    report_mismatch("persistence", int'(o_persistence),
                                    int'(pers_queue[0]));
                end
                void'(pers_queue.pop_front());
            end
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- multiplicative_persistence_unit.f -----
sv/mp_pkg.sv
sv/mp_bcd_conv.sv
sv/mp_digit_mult.sv
sv/multiplicative_persistence_unit.sv
sim/multiplicative_persistence_unit_tb.sv
